### rtl/core/bmvf_pkg.sv
// shared constants and types for the battery median voltage filter
`timescale 1ns / 1ps

package bmvf_pkg;

   localparam int WINDOW_LEN  = 5;
   localparam int ADC_BITS    = 12;
   localparam int SLOT_W      = $clog2(WINDOW_LEN);
   localparam int CNT_W       = $clog2(WINDOW_LEN + 1);
   localparam int MEDIAN_RANK = WINDOW_LEN / 2;

   localparam int MV_W     = 15;
   localparam int MV_IN_W  = 16;
   localparam int SCALE_W  = 24;
   localparam int OFFSET_W = 16;
   localparam int VOLT_W   = 16;
   localparam int TALLY_W  = 32;
   localparam int STATUS_W = 2;

   // shared multiplier: one operand is cut into slices of this width
   localparam int MUL_A_W  = 20;
   localparam int MUL_P_W  = MUL_A_W + SCALE_W;
   localparam int P1_W     = MV_W + SCALE_W;
   localparam int PROD_W   = P1_W + SCALE_W;
   localparam int SUM_W    = PROD_W + 1;
   localparam int FRAC_W   = 32;
   localparam int SCALED_W = SUM_W - FRAC_W;
   localparam int RES_W    = SCALED_W + 1;

   localparam logic [ADC_BITS-1:0] FULL_SCALE = {ADC_BITS{1'b1}};

   localparam logic [STATUS_W-1:0] ST_VALID     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FILLING   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ERROR     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd3;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_READY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDER   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET    = 2'd3;

   typedef struct packed {
      logic              clear;
      logic              write;
      logic [SLOT_W-1:0] slot;
      logic [MV_W-1:0]   data;
      logic [SLOT_W-1:0] cand_idx;
   } win_ctl_type;

   typedef struct packed {
      logic [MV_W-1:0] cand_value;
      logic            is_median;
   } win_stat_type;

endpackage

### rtl/core/battery_median_voltage_filter.sv
// battery median voltage filter: sequencer, counters, config and result register
// result: error, full-scale and filling samples give a result in the cycle after the
//   transfer; a full window goes through one rank step per window entry, 3 multiplier
//   passes, sum and result steps before the result shows
// flow: one sample at a time; the next transfer waits until the result has been taken
// reset: synchronous; clears window, counters, last values and config to defaults
`timescale 1ns / 1ps

module battery_median_voltage_filter import bmvf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ADC_BITS-1:0]   req_raw_code,
   input  logic                  req_read_failed,
   input  logic signed [MV_IN_W-1:0] req_calibrated_mv,
   input  logic                  req_calibration_failed,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [VOLT_W-1:0]     rsp_voltage_mv,
   output logic [CNT_W-1:0]      rsp_valid_samples,
   output logic [TALLY_W-1:0]    rsp_errors_seen,
   output logic [TALLY_W-1:0]    rsp_saturations_seen,
   output logic [ADC_BITS-1:0]   rsp_last_raw_code,
   output logic [MV_W-1:0]       rsp_last_good_mv
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_RANK    = 8'b0000_0010,
      S_MUL_DIV = 8'b0000_0100,
      S_MUL_LO  = 8'b0000_1000,
      S_MUL_HI  = 8'b0001_0000,
      S_SUM     = 8'b0010_0000,
      S_RESULT  = 8'b0100_0000,
      S_OUT     = 8'b1000_0000
   } state_type;

   function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] v);
      return (v == {TALLY_W{1'b1}}) ? v : v + TALLY_W'(1);
   endfunction

   state_type state_ff, state_in;

   logic                       cal_ready_ff;
   logic [SCALE_W-1:0]         divider_ff;
   logic [SCALE_W-1:0]         gain_ff;
   logic signed [OFFSET_W-1:0] offset_ff;

   logic [CNT_W-1:0]    fill_ff, fill_in, fill_next;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [TALLY_W-1:0]  err_ff, err_in;
   logic [TALLY_W-1:0]  sat_ff, sat_in;
   logic [ADC_BITS-1:0] recent_raw_ff, recent_raw_in;
   logic [MV_W-1:0]     recent_mv_ff, recent_mv_in;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic [VOLT_W-1:0]   volt_ff, volt_in;
   logic [SLOT_W-1:0]   cand_ff, cand_in;
   logic [MV_W-1:0]     median_ff, median_in;
   logic [P1_W-1:0]     p1_ff, p1_in;
   logic [MUL_P_W-1:0]  lo_ff, lo_in;
   logic [SCALED_W-1:0] scaled_ff, scaled_in;

   logic [SUM_W-1:0]        prod_sum;
   logic signed [RES_W-1:0] res;

   win_ctl_type        win_ctl;
   win_stat_type       win_stat;
   logic [MUL_A_W-1:0] mul_a;
   logic [SCALE_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_p;

   bmvf_window u_window (
      .clock (clock),
      .reset (reset),
      .ctl   (win_ctl),
      .stat  (win_stat)
   );

   bmvf_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ready_ff <= 1'b0;
         divider_ff   <= SCALE_W'(65536);
         gain_ff      <= SCALE_W'(65536);
         offset_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CAL_READY: cal_ready_ff <= csr_wdata[0];
            CSR_DIVIDER:   divider_ff   <= csr_wdata[SCALE_W-1:0];
            CSR_GAIN:      gain_ff      <= csr_wdata[SCALE_W-1:0];
            CSR_OFFSET:    offset_ff    <= csr_wdata[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      slot_in       = slot_ff;
      err_in        = err_ff;
      sat_in        = sat_ff;
      recent_raw_in = recent_raw_ff;
      recent_mv_in  = recent_mv_ff;
      status_in     = status_ff;
      volt_in       = volt_ff;
      cand_in       = cand_ff;
      median_in     = median_ff;
      p1_in         = p1_ff;
      lo_in         = lo_ff;
      scaled_in     = scaled_ff;
      win_ctl       = '0;
      mul_a         = '0;
      mul_b         = '0;
      fill_next     = (fill_ff < CNT_W'(WINDOW_LEN)) ? fill_ff + CNT_W'(1) : fill_ff;
      prod_sum      = SUM_W'(lo_ff) + (SUM_W'(mul_p) << MUL_A_W)
                      + (SUM_W'(1) << (FRAC_W - 1));
      res           = $signed({1'b0, scaled_ff}) + RES_W'(offset_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in  = S_OUT;
               volt_in   = '0;
               status_in = ST_ERROR;
               if (!cal_ready_ff) begin
                  err_in        = sat_inc(err_ff);
                  win_ctl.clear = 1'b1;
                  fill_in       = '0;
                  slot_in       = '0;
               end else begin
                  recent_raw_in = req_raw_code;
                  if (req_read_failed) begin
                     err_in        = sat_inc(err_ff);
                     win_ctl.clear = 1'b1;
                     fill_in       = '0;
                     slot_in       = '0;
                  end else if (req_raw_code >= FULL_SCALE) begin
                     sat_in        = sat_inc(sat_ff);
                     status_in     = ST_SATURATED;
                     win_ctl.clear = 1'b1;
                     fill_in       = '0;
                     slot_in       = '0;
                  end else if (req_calibration_failed || req_calibrated_mv[MV_IN_W-1]) begin
                     err_in        = sat_inc(err_ff);
                     win_ctl.clear = 1'b1;
                     fill_in       = '0;
                     slot_in       = '0;
                  end else begin
                     recent_mv_in  = req_calibrated_mv[MV_W-1:0];
                     win_ctl.write = 1'b1;
                     win_ctl.slot  = slot_ff;
                     win_ctl.data  = req_calibrated_mv[MV_W-1:0];
                     slot_in       = (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ?
                                     '0 : slot_ff + SLOT_W'(1);
                     fill_in       = fill_next;
                     if (fill_next < CNT_W'(WINDOW_LEN)) begin
                        status_in = ST_FILLING;
                     end else begin
                        cand_in  = '0;
                        state_in = S_RANK;
                     end
                  end
               end
            end
         end
         S_RANK: begin
            win_ctl.cand_idx = cand_ff;
            if (win_stat.is_median) begin
               median_in = win_stat.cand_value;
            end
            if (cand_ff == SLOT_W'(WINDOW_LEN - 1)) begin
               state_in = S_MUL_DIV;
            end else begin
               cand_in = cand_ff + SLOT_W'(1);
            end
         end
         S_MUL_DIV: begin
            mul_a    = MUL_A_W'(median_ff);
            mul_b    = divider_ff;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            // median times divider is back; split it across two gain passes
            p1_in    = mul_p[P1_W-1:0];
            mul_a    = mul_p[MUL_A_W-1:0];
            mul_b    = gain_ff;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            lo_in    = mul_p;
            mul_a    = MUL_A_W'(p1_ff[P1_W-1:MUL_A_W]);
            mul_b    = gain_ff;
            state_in = S_SUM;
         end
         S_SUM: begin
            // rounded half up to whole millivolts
            scaled_in = prod_sum[SUM_W-1:FRAC_W];
            state_in  = S_RESULT;
         end
         S_RESULT: begin
            state_in = S_OUT;
            if (res[RES_W-1]) begin
               err_in        = sat_inc(err_ff);
               win_ctl.clear = 1'b1;
               fill_in       = '0;
               slot_in       = '0;
               status_in     = ST_ERROR;
               volt_in       = '0;
            end else begin
               status_in = ST_VALID;
               volt_in   = (|res[RES_W-2:VOLT_W]) ? {VOLT_W{1'b1}} : res[VOLT_W-1:0];
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         slot_ff       <= '0;
         err_ff        <= '0;
         sat_ff        <= '0;
         recent_raw_ff <= '0;
         recent_mv_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         slot_ff       <= slot_in;
         err_ff        <= err_in;
         sat_ff        <= sat_in;
         recent_raw_ff <= recent_raw_in;
         recent_mv_ff  <= recent_mv_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      volt_ff   <= volt_in;
      cand_ff   <= cand_in;
      median_ff <= median_in;
      p1_ff     <= p1_in;
      lo_ff     <= lo_in;
      scaled_ff <= scaled_in;
   end

   assign req_ready            = (state_ff == S_IDLE);
   assign rsp_valid            = (state_ff == S_OUT);
   assign rsp_status           = status_ff;
   assign rsp_voltage_mv       = volt_ff;
   assign rsp_valid_samples    = fill_ff;
   assign rsp_errors_seen      = err_ff;
   assign rsp_saturations_seen = sat_ff;
   assign rsp_last_raw_code    = recent_raw_ff;
   assign rsp_last_good_mv     = recent_mv_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(WINDOW_LEN))
      else $error("window fill count above window length");

   a_slot_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      (fill_ff < CNT_W'(WINDOW_LEN)) |-> (CNT_W'(slot_ff) == fill_ff))
      else $error("write slot out of step with fill count");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken again before result transfer");

   a_valid_needs_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_VALID) |-> (rsp_valid_samples == CNT_W'(WINDOW_LEN)))
      else $error("voltage reported without a full window");

   a_fault_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_ERROR || rsp_status == ST_SATURATED))
      |-> (rsp_valid_samples == '0 && rsp_voltage_mv == '0))
      else $error("fault result left window or voltage set");

endmodule

### rtl/core/bmvf_window.sv
// sample window ring with one-candidate-per-cycle rank compare
`timescale 1ns / 1ps

module bmvf_window import bmvf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  win_ctl_type  ctl,
   output win_stat_type stat
);

   logic [MV_W-1:0]  win_ff [WINDOW_LEN];
   logic [MV_W-1:0]  cand;
   logic [CNT_W-1:0] rank;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            win_ff[i] <= '0;
         end
      end else if (ctl.write) begin
         win_ff[ctl.slot] <= ctl.data;
      end
   end

   // stable rank: smaller entries, plus equal entries at lower slots
   always_comb begin
      cand = win_ff[ctl.cand_idx];
      rank = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
         if ((win_ff[j] < cand) ||
             ((win_ff[j] == cand) && (SLOT_W'(j) < ctl.cand_idx))) begin
            rank = rank + CNT_W'(1);
         end
      end
   end

   assign stat.cand_value = cand;
   assign stat.is_median  = (rank == CNT_W'(MEDIAN_RANK));

endmodule

### rtl/core/bmvf_mul.sv
// shared registered multiplier for the scaling steps
`timescale 1ns / 1ps

module bmvf_mul import bmvf_pkg::*; (
   input  logic               clock,
   input  logic [MUL_A_W-1:0] mul_a,
   input  logic [SCALE_W-1:0] mul_b,
   output logic [MUL_P_W-1:0] mul_p
);

   logic [MUL_P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
   end

   assign mul_p = prod_ff;

endmodule

### verif/battery_median_voltage_filter_tb.sv
// self-checking testbench for the battery median voltage filter
`timescale 1ns / 1ps

module battery_median_voltage_filter_tb;
   import bmvf_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_LEN      = 300;
   localparam int REPORT_MAX    = 10;

   typedef struct {
      logic [ADC_BITS-1:0]       raw;
      logic                      read_failed;
      logic signed [MV_IN_W-1:0] mv;
      logic                      cal_failed;
   } conversion_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VOLT_W-1:0]   voltage;
      logic [CNT_W-1:0]    fill;
      logic [TALLY_W-1:0]  errors;
      logic [TALLY_W-1:0]  sats;
      logic [ADC_BITS-1:0] raw;
      logic [MV_W-1:0]     mv;
   } filter_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [ADC_BITS-1:0]       req_raw_code = '0;
   logic                      req_read_failed = 1'b0;
   logic signed [MV_IN_W-1:0] req_calibrated_mv = '0;
   logic                      req_calibration_failed = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic [VOLT_W-1:0]         rsp_voltage_mv;
   logic [CNT_W-1:0]          rsp_valid_samples;
   logic [TALLY_W-1:0]        rsp_errors_seen;
   logic [TALLY_W-1:0]        rsp_saturations_seen;
   logic [ADC_BITS-1:0]       rsp_last_raw_code;
   logic [MV_W-1:0]           rsp_last_good_mv;

   battery_median_voltage_filter dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_raw_code           (req_raw_code),
      .req_read_failed        (req_read_failed),
      .req_calibrated_mv      (req_calibrated_mv),
      .req_calibration_failed (req_calibration_failed),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_status             (rsp_status),
      .rsp_voltage_mv         (rsp_voltage_mv),
      .rsp_valid_samples      (rsp_valid_samples),
      .rsp_errors_seen        (rsp_errors_seen),
      .rsp_saturations_seen   (rsp_saturations_seen),
      .rsp_last_raw_code      (rsp_last_raw_code),
      .rsp_last_good_mv       (rsp_last_good_mv)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state and register copy
   logic [MV_W-1:0]           win_copy [WINDOW_LEN];
   logic [CNT_W-1:0]          fill_copy;
   logic [SLOT_W-1:0]         slot_copy;
   logic [TALLY_W-1:0]        error_copy;
   logic [TALLY_W-1:0]        sat_copy;
   logic [ADC_BITS-1:0]       raw_copy;
   logic [MV_W-1:0]           mv_copy;
   logic                      ready_reg;
   logic [SCALE_W-1:0]        divider_reg;
   logic [SCALE_W-1:0]        gain_reg;
   logic signed [OFFSET_W-1:0] offset_reg;

   filter_result_type expected_results [$];

   int samples_sent = 0;
   int results_seen = 0;
   int mismatch_count = 0;
   int settings_programmed = 0;
   int status_count [4] = '{0, 0, 0, 0};
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;

   function automatic void clear_window_copy();
      foreach (win_copy[i]) win_copy[i] = '0;
      fill_copy = '0;
      slot_copy = '0;
   endfunction

   function automatic void reset_filter_copy();
      clear_window_copy();
      error_copy  = '0;
      sat_copy    = '0;
      raw_copy    = '0;
      mv_copy     = '0;
      ready_reg   = 1'b0;
      divider_reg = SCALE_W'(65536);
      gain_reg    = SCALE_W'(65536);
      offset_reg  = '0;
   endfunction

   function automatic void write_reg_copy(input logic [CSR_IDX_W-1:0] index,
                                          input logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_CAL_READY: ready_reg   = data[0];
         CSR_DIVIDER:   divider_reg = data[SCALE_W-1:0];
         CSR_GAIN:      gain_reg    = data[SCALE_W-1:0];
         CSR_OFFSET:    offset_reg  = data[OFFSET_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void count_error();
      if (error_copy != '1) error_copy++;
      clear_window_copy();
   endfunction

   function automatic filter_result_type predict_conversion(input conversion_type c);
      filter_result_type r;
      logic [MV_W-1:0] sorted [WINDOW_LEN];
      logic [MV_W-1:0] tmp;
      logic [63:0]     product;
      logic [63:0]     rounded;
      longint          level;
      r = '0;
      if (!ready_reg) begin
         count_error();
         r.status = ST_ERROR;
      end else begin
         raw_copy = c.raw;
         if (c.read_failed) begin
            count_error();
            r.status = ST_ERROR;
         end else if (c.raw >= FULL_SCALE) begin
            if (sat_copy != '1) sat_copy++;
            clear_window_copy();
            r.status = ST_SATURATED;
         end else if (c.cal_failed || c.mv[MV_IN_W-1]) begin
            count_error();
            r.status = ST_ERROR;
         end else begin
            mv_copy = c.mv[MV_W-1:0];
            win_copy[slot_copy] = mv_copy;
            slot_copy = (slot_copy == WINDOW_LEN - 1) ? '0 : slot_copy + 1'b1;
            if (fill_copy < WINDOW_LEN) fill_copy++;
            if (fill_copy < WINDOW_LEN) begin
               r.status = ST_FILLING;
            end else begin
               sorted = win_copy;
               for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                  for (int j = 0; j < WINDOW_LEN - 1 - i; j++) begin
                     if (sorted[j] > sorted[j+1]) begin
                        tmp = sorted[j];
                        sorted[j] = sorted[j+1];
                        sorted[j+1] = tmp;
                     end
                  end
               end
               product = 64'(sorted[MEDIAN_RANK]) * 64'(divider_reg) * 64'(gain_reg);
               // Q.32 product rounded half up to whole millivolts
               rounded = (product + 64'h8000_0000) >> 32;
               level = longint'(rounded) + longint'(offset_reg);
               if (level < 0) begin
                  count_error();
                  r.status = ST_ERROR;
               end else begin
                  r.voltage = (level > 65535) ? '1 : level[VOLT_W-1:0];
                  r.status = ST_VALID;
               end
            end
         end
      end
      r.fill   = fill_copy;
      r.errors = error_copy;
      r.sats   = sat_copy;
      r.raw    = raw_copy;
      r.mv     = mv_copy;
      return r;
   endfunction

   // register writes, result checks and sample transfers, all sampled at the edge
   always @(posedge clock) begin : monitor
      filter_result_type got;
      filter_result_type want;
      conversion_type    taken;
      if (reset) begin
         reset_filter_copy();
      end else begin
         if (csr_we) write_reg_copy(csr_index, csr_wdata);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_voltage_mv, rsp_valid_samples, rsp_errors_seen,
                   rsp_saturations_seen, rsp_last_raw_code, rsp_last_good_mv};
            results_seen++;
            status_count[got.status]++;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("unexpected result: st=%0d v=%0d n=%0d err=%0d sat=%0d raw=%h mv=%0d",
                           got.status, got.voltage, got.fill, got.errors, got.sats,
                           got.raw, got.mv);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX) begin
                     $display("mismatch at cycle %0d", cycle_count);
                     $display("  expected st=%0d v=%0d n=%0d err=%0d sat=%0d raw=%h mv=%0d",
                              want.status, want.voltage, want.fill, want.errors, want.sats,
                              want.raw, want.mv);
                     $display("  actual   st=%0d v=%0d n=%0d err=%0d sat=%0d raw=%h mv=%0d",
                              got.status, got.voltage, got.fill, got.errors, got.sats,
                              got.raw, got.mv);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            taken = '{req_raw_code, req_read_failed, req_calibrated_mv, req_calibration_failed};
            expected_results.push_back(predict_conversion(taken));
         end
      end
   end

   // result side: random stalls plus a long hold-off on request
   always @(posedge clock) begin : receiver
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_LEN;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("cycle limit of %0d reached", CYCLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   // valid stays high after a transfer only when the next sample follows at once
   task automatic send_conversion(input conversion_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_raw_code           <= c.raw;
      req_read_failed        <= c.read_failed;
      req_calibrated_mv      <= c.mv;
      req_calibration_failed <= c.cal_failed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      samples_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (results_seen < samples_sent) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input logic ready, input logic [SCALE_W-1:0] divider,
                               input logic [SCALE_W-1:0] gain,
                               input logic [OFFSET_W-1:0] offset);
      csr_we    <= 1'b1;
      csr_index <= CSR_CAL_READY;
      csr_wdata <= CSR_DATA_W'(ready);
      @(posedge clock);
      csr_index <= CSR_DIVIDER;
      csr_wdata <= CSR_DATA_W'(divider);
      @(posedge clock);
      csr_index <= CSR_GAIN;
      csr_wdata <= CSR_DATA_W'(gain);
      @(posedge clock);
      csr_index <= CSR_OFFSET;
      csr_wdata <= CSR_DATA_W'(offset);
      @(posedge clock);
      csr_we <= 1'b0;
      settings_programmed++;
   endtask

   function automatic conversion_type make_conversion(input logic [ADC_BITS-1:0] raw,
                                                      input logic rf, input int mv,
                                                      input logic cf);
      conversion_type c;
      c.raw         = raw;
      c.read_failed = rf;
      c.mv          = MV_IN_W'(mv);
      c.cal_failed  = cf;
      return c;
   endfunction

   // mostly clean samples so the window fills; the rest are faults of each kind
   function automatic conversion_type random_conversion();
      conversion_type c;
      int             roll;
      roll          = $urandom_range(99);
      c.raw         = ADC_BITS'($urandom_range(0, 4094));
      c.read_failed = 1'b0;
      c.cal_failed  = 1'b0;
      c.mv          = MV_IN_W'($urandom_range(0, 32767));
      if (roll < 3) begin
         c.read_failed = 1'b1;
         c.raw         = ADC_BITS'($urandom);
         c.cal_failed  = 1'($urandom);
         c.mv          = MV_IN_W'($urandom);
      end else if (roll < 6) begin
         c.raw        = FULL_SCALE;
         c.cal_failed = 1'($urandom);
         c.mv         = MV_IN_W'($urandom);
      end else if (roll < 9) begin
         c.cal_failed = 1'b1;
         c.mv         = MV_IN_W'($urandom);
      end else if (roll < 12) begin
         c.mv[MV_IN_W-1] = 1'b1;
      end
      return c;
   endfunction

   function automatic logic [SCALE_W-1:0] random_scale();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return SCALE_W'($urandom);
         3:       return SCALE_W'($urandom_range(0, 131072));
         default: return SCALE_W'($urandom_range(57344, 73728));
      endcase
   endfunction

   task automatic test_not_ready();
      // reset defaults: every sample is an error and the raw code is not kept
      send_conversion(make_conversion(12'h5A5, 1'b0, 1234, 1'b0));
      send_conversion(make_conversion(FULL_SCALE, 1'b1, -1, 1'b1));
      wait_idle();
   endtask

   task automatic test_sample_faults();
      program_regs(1'b1, SCALE_W'(65536), SCALE_W'(65536), '0);
      send_conversion(make_conversion(12'hABC, 1'b1, 500, 1'b0));
      send_conversion(make_conversion(FULL_SCALE, 1'b0, 500, 1'b0));
      send_conversion(make_conversion(12'h3C3, 1'b0, 700, 1'b1));
      send_conversion(make_conversion(12'h123, 1'b0, -32768, 1'b0));
      send_conversion(make_conversion(12'h7FF, 1'b0, -1, 1'b0));
      wait_idle();
   endtask

   task automatic test_window_median();
      send_conversion(make_conversion(12'h000, 1'b0, 32767, 1'b0));
      send_conversion(make_conversion(12'hFFE, 1'b0, 0, 1'b0));
      send_conversion(make_conversion(12'h555, 1'b0, 100, 1'b0));
      send_conversion(make_conversion(12'hAAA, 1'b0, 5, 1'b0));
      send_conversion(make_conversion(12'h0F0, 1'b0, 20000, 1'b0));
      // ring wraps and the oldest entry is replaced
      send_conversion(make_conversion(12'hF0F, 1'b0, 7, 1'b0));
      wait_idle();
   endtask

   task automatic test_scaling_extremes();
      int i;
      // zero scale gives a valid zero, a negative offset then turns it into an error
      program_regs(1'b1, '0, '1, '0);
      send_conversion(make_conversion(12'h321, 1'b0, 300, 1'b0));
      wait_idle();
      program_regs(1'b1, '0, '1, OFFSET_W'(-1));
      send_conversion(make_conversion(12'h321, 1'b0, 200, 1'b0));
      wait_idle();
      program_regs(1'b1, '1, '1, OFFSET_W'(32767));
      for (i = 0; i < WINDOW_LEN; i++)
         send_conversion(make_conversion(12'h400, 1'b0, (i % 2) ? i : 32767, 1'b0));
      wait_idle();
      // largest median with unity scale lands just below zero
      program_regs(1'b1, SCALE_W'(65536), SCALE_W'(65536), OFFSET_W'(-32768));
      for (i = 0; i < WINDOW_LEN; i++)
         send_conversion(make_conversion(12'h200, 1'b0, 32767, 1'b0));
      wait_idle();
   endtask

   task automatic test_random_traffic(input int total, input int send_pct, input int recv_pct);
      int left;
      int chunk;
      int off;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      left = total;
      while (left > 0) begin
         wait_idle();
         case ($urandom_range(4))
            0:       off = -32768;
            1:       off = 32767;
            2:       off = int'($urandom_range(0, 65535)) - 32768;
            default: off = int'($urandom_range(0, 600)) - 300;
         endcase
         program_regs($urandom_range(9) != 0, random_scale(), random_scale(), OFFSET_W'(off));
         chunk = $urandom_range(60, 140);
         if (chunk > left) chunk = left;
         repeat (chunk) send_conversion(random_conversion());
         left -= chunk;
      end
      wait_idle();
   endtask

   task automatic test_receiver_holdoff();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_regs(1'b1, SCALE_W'(65536), SCALE_W'(70000), OFFSET_W'(25));
      hold_token++;
      repeat (30) send_conversion(random_conversion());
      wait_idle();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_not_ready();
      test_sample_faults();
      test_window_median();
      test_scaling_extremes();
      test_random_traffic(400, 32, 57);
      test_receiver_holdoff();
      test_random_traffic(400, 57, 32);
      test_random_traffic(400, 0, 0);
      wait_idle();
      $display("covered %0d conversions under %0d register settings, %0d results checked",
               samples_sent, settings_programmed, results_seen);
      $display("outcomes: %0d valid, %0d filling, %0d error, %0d full-scale",
               status_count[ST_VALID], status_count[ST_FILLING], status_count[ST_ERROR],
               status_count[ST_SATURATED]);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         if (expected_results.size() != 0)
            $display("%0d expected results never arrived", expected_results.size());
         $display("%0d mismatching or unexpected results", mismatch_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
